>>> rtl/core/ddf_pkg.sv
package ddf_pkg;

    // request kinds
    typedef enum logic
    {
        CMD_VALUE = 1'b0,
        CMD_TIME  = 1'b1
    } cmd_t;

    localparam logic [3:0] GLYPH_BLANK    = 4'd10;
    localparam logic [3:0] TIME_POSITIONS = 4'd4;
    localparam logic [2:0] COLON_POSITION = 3'd2;
    localparam int         POS_LIMIT      = 8;
    localparam logic [6:0] PART_MAX       = 7'd99;

    // reciprocal of ten, exact for 32-bit operands with a shift of 35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // classified request as held between front and back
    typedef struct packed {
        cmd_t        mode;
        logic [3:0]  count;
        logic [31:0] data;
    } ddf_entry_t;

    // one position write
    typedef struct packed {
        logic [2:0] position;
        logic [3:0] glyph;
        logic       aux_write;
        logic       aux_on;
        logic       last;
    } ddf_result_t;

endpackage

>>> rtl/core/decimal_display_digit_formatter.sv
// Decimal display digit formatter: turns display requests into position writes.
// Input channel: push/full. A request is taken at an edge with push high and
// full low. command 0 shows value in decimal over digit_count positions with
// leading positions blanked; command 1 shows first_part:second_part on four
// positions with the colon at position 2.
// Result channel: empty/pop. The oldest position write sits on position, glyph,
// aux_write, aux_on and last while empty is low; pop high takes it. Writes come
// in ascending position order, last marks the final one of each request.
// Config channel: cfg_valid/cfg_ready/cfg_data sets digit_count; cfg_ready is
// always high. Change it only while no request is in flight.
// Throughput: one position write per cycle while the output register is empty
// or popped; a request has up to eight positions. The sequencer performs one
// divide by ten per cycle under the same condition. A two-entry queue sits
// between the request classifier and the sequencer.
// Reset: digit_count returns to 4, queue and output register empty.
// When pop stays low the output register holds, the sequencer stops, and full
// rises once the queue holds two requests.
module decimal_display_digit_formatter #(
    parameter int MAX_DIGITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [31:0] value,
    input  logic [6:0]  first_part,
    input  logic [6:0]  second_part,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  position,
    output logic [3:0]  glyph,
    output logic        aux_write,
    output logic        aux_on,
    output logic        last
);
    import ddf_pkg::*;

    logic        keep;
    logic        accept;
    ddf_entry_t  front_entry;
    logic        q_valid;
    logic        q_take;
    ddf_entry_t  q_entry;
    logic        out_valid;
    ddf_result_t out_result;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // request classifier and digit count register
    ddf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .command     (command),
        .value       (value),
        .first_part  (first_part),
        .second_part (second_part),
        .keep        (keep),
        .entry       (front_entry)
    );

    // decoupling queue
    ddf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && keep),
        .wr_entry (front_entry),
        .rd_en    (q_take),
        .full     (full),
        .rd_valid (q_valid),
        .rd_entry (q_entry)
    );

    // digit sequencer and output register
    ddf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_take     (q_take),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_result (out_result)
    );

    assign empty     = !out_valid;
    assign position  = out_result.position;
    assign glyph     = out_result.glyph;
    assign aux_write = out_result.aux_write;
    assign aux_on    = out_result.aux_on;
    assign last      = out_result.last;

`ifndef ASSERT_OFF
    // a position without a digit write is a blank
    a_blank_no_aux: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !aux_write) |-> (glyph == GLYPH_BLANK))
        else $error("unwritten aux segment on a digit glyph");

    // the colon only ever lights at its own position
    a_colon_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && aux_on) |-> (aux_write && position == COLON_POSITION))
        else $error("aux segment lit away from colon position");

    // writes of one request step through positions in order
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(pop && !empty && !last) && !empty)
            |-> (position == 3'($past(position) + 3'd1)))
        else $error("position sequence broken");
`endif

endmodule

>>> rtl/core/ddf_front.sv
module ddf_front #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [3:0]          cfg_data,
    input  logic                command,
    input  logic [31:0]         value,
    input  logic [6:0]          first_part,
    input  logic [6:0]          second_part,
    output logic                keep,
    output ddf_pkg::ddf_entry_t entry
);
    import ddf_pkg::*;

    localparam int COUNT_LIMIT = (MAX_DIGITS < POS_LIMIT) ? MAX_DIGITS : POS_LIMIT;

    logic [3:0]  digit_count_reg;
    logic [3:0]  count_lim;
    logic [6:0]  part_a;
    logic [6:0]  part_b;
    logic [14:0] prod_a;
    logic [14:0] prod_b;
    logic [3:0]  tens_a;
    logic [3:0]  ones_a;
    logic [3:0]  tens_b;
    logic [3:0]  ones_b;
    logic [3:0]  glyph_tens_a;

    // digit count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= 4'd4;
        end
        else if (cfg_valid)
        begin
            digit_count_reg <= cfg_data;
        end
    end

    // clamp the count to the display limit
    always_comb
    begin
        if (digit_count_reg > 4'(COUNT_LIMIT))
        begin
            count_lim = 4'(COUNT_LIMIT);
        end
        else
        begin
            count_lim = digit_count_reg;
        end
    end

    // saturate time parts and split into tens and ones (x * 205 >> 11)
    always_comb
    begin
        part_a       = (first_part > PART_MAX) ? PART_MAX : first_part;
        part_b       = (second_part > PART_MAX) ? PART_MAX : second_part;
        prod_a       = 15'(part_a) * 15'd205;
        prod_b       = 15'(part_b) * 15'd205;
        tens_a       = prod_a[14:11];
        tens_b       = prod_b[14:11];
        ones_a       = part_a[3:0] - 4'({tens_a, 3'b000} + {tens_a, 1'b0});
        ones_b       = part_b[3:0] - 4'({tens_b, 3'b000} + {tens_b, 1'b0});
        glyph_tens_a = (part_a >= 7'd10) ? tens_a : GLYPH_BLANK;
    end

    // build the queue entry, value requests with no positions are dropped
    always_comb
    begin
        if (cmd_t'(command) == CMD_TIME)
        begin
            entry.mode  = CMD_TIME;
            entry.count = TIME_POSITIONS;
            entry.data  = {16'd0, glyph_tens_a, ones_a, tens_b, ones_b};
            keep        = 1'b1;
        end
        else
        begin
            entry.mode  = CMD_VALUE;
            entry.count = count_lim;
            entry.data  = value;
            keep        = (count_lim != 4'd0);
        end
    end

endmodule

>>> rtl/core/ddf_queue.sv
module ddf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ddf_pkg::ddf_entry_t wr_entry,
    input  logic                rd_en,
    output logic                full,
    output logic                rd_valid,
    output ddf_pkg::ddf_entry_t rd_entry
);
    import ddf_pkg::*;

    ddf_entry_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_entry = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> rtl/core/ddf_back.sv
module ddf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ddf_pkg::ddf_entry_t  q_entry,
    output logic                 q_take,
    input  logic                 pop,
    output logic                 out_valid,
    output ddf_pkg::ddf_result_t out_result
);
    import ddf_pkg::*;

    logic        busy_reg;
    logic        busy_next;
    cmd_t        mode_reg;
    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic [2:0]  pos_reg;
    logic [3:0]  count_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    ddf_result_t result_reg;
    ddf_result_t result_next;
    logic        advance;
    logic        last_pos;
    logic        take;
    logic [63:0] prod;
    logic [28:0] quot;
    logic [3:0]  digit;

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // one position per cycle while the output register has room
    always_comb
    begin
        advance  = busy_reg && (!out_valid_reg || pop);
        last_pos = ((4'(pos_reg) + 4'd1) == count_reg);
        take     = !busy_reg || (advance && last_pos);
        q_take   = take && q_valid;
    end

    // divide by ten through the reciprocal, remainder from the low bits
    always_comb
    begin
        prod  = 64'(data_reg) * 64'(RECIP_TEN);
        quot  = prod[63:RECIP_SHIFT];
        digit = data_reg[3:0] - 4'({quot[3:0], 3'b000} + {quot[3:0], 1'b0});
    end

    // result for the current position
    always_comb
    begin
        result_next.position = pos_reg;
        result_next.last     = last_pos;
        if (mode_reg == CMD_TIME)
        begin
            result_next.glyph     = data_reg[3:0];
            result_next.aux_write = 1'b1;
            result_next.aux_on    = (pos_reg == COLON_POSITION);
            data_next             = {4'd0, data_reg[31:4]};
        end
        else
        begin
            if (data_reg == 32'd0 && pos_reg != 3'd0)
            begin
                result_next.glyph     = GLYPH_BLANK;
                result_next.aux_write = 1'b0;
            end
            else
            begin
                result_next.glyph     = digit;
                result_next.aux_write = 1'b1;
            end
            result_next.aux_on = 1'b0;
            data_next          = {3'd0, quot};
        end
    end

    // busy and output valid control
    always_comb
    begin
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = q_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers of the digit sequencer
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            mode_reg  <= q_entry.mode;
            data_reg  <= q_entry.data;
            count_reg <= q_entry.count;
            pos_reg   <= 3'd0;
        end
        else if (advance)
        begin
            data_reg <= data_next;
            pos_reg  <= pos_reg + 3'd1;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule
